@@ hw/rtl/tfrm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the color preset table of the transfer function map.
package tfrm_pkg;

  // Table size and field widths.
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = 8;
  localparam int Q_W           = 16;
  localparam int NUM_CH        = 3;

  localparam logic [Q_W-1:0] Q_ONE  = 16'd32768;
  localparam logic [Q_W-1:0] Q_HALF = 16'd16384;

  // Configuration port.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int PRESET_W    = 2;
  localparam int THR_W       = 15;
  localparam int MAX_ALPHA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALPHA = 2'd2;

  localparam logic [PRESET_W-1:0]    PRESET_RESET    = 2'd0;
  localparam logic [THR_W-1:0]       THR_RESET       = 15'd0;
  localparam logic [MAX_ALPHA_W-1:0] MAX_ALPHA_RESET = 16'd4096;

  // Position t = floor(idx * 32768 / TableLast), done as a multiply by a
  // rounded-up reciprocal. The 40-bit scale keeps it exact for every index.
  localparam logic [63:0] TableLast = 64'(TABLE_ENTRIES - 1);
  localparam int T_SHIFT   = 40;
  localparam int T_RECIP_W = 41;
  localparam logic [T_RECIP_W-1:0] T_RECIP =
    T_RECIP_W'(((64'd1 << T_SHIFT) + TableLast - 64'd1) / TableLast);
  localparam int T_PROD_W = IDX_W + T_RECIP_W;
  localparam int T_DROP   = T_SHIFT - 15;
  localparam int T_RAW_W  = T_PROD_W - T_DROP;

  // Blend and opacity arithmetic widths.
  localparam int DIFF_W  = Q_W + 1;
  localparam int CPROD_W = 2 * DIFF_W;
  localparam int APROD_W = MAX_ALPHA_W + Q_W;
  localparam int NUM_W   = APROD_W + 3;

  // Opacity divider: 15 quotient bits, three per stage.
  localparam int DIV_Q_W      = 15;
  localparam int DIV_BITS     = 3;
  localparam int DIV_STAGES   = DIV_Q_W / DIV_BITS;
  localparam int REM_W        = 30;
  localparam int PIPE_LATENCY = 5 + DIV_STAGES;

  typedef logic [Q_W-1:0] q15_t;

  typedef struct packed {
    q15_t red;
    q15_t green;
    q15_t blue;
  } rgb_t;

  // One transaction in flight through the opacity divider.
  typedef struct packed {
    logic               valid;
    logic               sat;
    logic [REM_W-1:0]   rem;
    logic [Q_W-1:0]     den;
    logic [DIV_Q_W-1:0] quo;
  } div_op_t;

  // Preset colors [preset][low, mid, high][r, g, b] in Q1.15.
  localparam q15_t COLOUR_TAB [0:3][0:2][0:2] = '{
    '{'{16'd0,     16'd0,     16'd0},
      '{16'd32768, 16'd9830,  16'd0},
      '{16'd32768, 16'd32768, 16'd32768}},
    '{'{16'd1638,  16'd1638,  16'd29491},
      '{16'd24576, 16'd24576, 16'd24576},
      '{16'd29491, 16'd3277,  16'd3277}},
    '{'{16'd3277,  16'd1638,  16'd1638},
      '{16'd24576, 16'd18022, 16'd13107},
      '{16'd32768, 16'd31130, 16'd27853}},
    '{'{16'd0,     16'd0,     16'd0},
      '{16'd16384, 16'd16384, 16'd16384},
      '{16'd32768, 16'd32768, 16'd32768}}
  };

endpackage

@@ hw/rtl/tfrm_alpha_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider that forms the opacity quotient, three bits per stage.
module tfrm_alpha_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tfrm_pkg::div_op_t op_in,
  output tfrm_pkg::div_op_t op_out
);
  import tfrm_pkg::*;

  div_op_t stage_in  [0:DIV_STAGES-1];
  div_op_t stage_nxt [0:DIV_STAGES-1];
  div_op_t stage_r   [0:DIV_STAGES-1];

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_stage
      // Stage 0 takes op_in; each later stage takes its operand from the previous stage register.
      if (s == 0) begin : g_first
        assign stage_in[s] = op_in;
      end else begin : g_next
        assign stage_in[s] = stage_r[s-1];
      end

      // Three restoring steps: subtract the shifted divisor where it fits.
      always_comb begin
        div_op_t          cur;
        logic [REM_W-1:0] trial;
        cur   = stage_in[s];
        trial = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
          trial = {{(REM_W-Q_W){1'b0}}, cur.den} << (DIV_Q_W - 1 - s * DIV_BITS - j);
          if (cur.rem >= trial) begin
            cur.rem = cur.rem - trial;
            cur.quo[DIV_Q_W - 1 - s * DIV_BITS - j] = 1'b1;
          end
        end
        stage_nxt[s] = cur;
      end

      // Only the valid bit needs a reset value.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stage_r[s].valid <= 1'b0;
        end else begin
          stage_r[s] <= stage_nxt[s];
        end
      end
    end
  endgenerate

  assign op_out = stage_r[DIV_STAGES-1];

endmodule

@@ hw/rtl/transfer_function_rgba_map_top.sv @@
`timescale 1ns / 1ps
// Top level of the piecewise-linear color map with opacity ramp.
//
// Usage:
//   Input: drive in_sample_index with start high; the transaction is taken at
//   any rising edge where start is high and busy is low. busy stays low, so a
//   new sample may enter in every cycle.
//   Output: each sample produces one result, shown for exactly one cycle with
//   out_valid high on out_red, out_green, out_blue and out_opacity (Q1.15).
//   Throughput is one sample per cycle. A sample passes through five front
//   stages (index clamp, position, segment and table lookup, multiplies,
//   blend sum and saturation check) and then the five-stage opacity divider.
//   The receiver cannot stall: results leave in acceptance order, one per
//   cycle at most, and are never held back.
//   Configuration: cfg_we with cfg_index 0 (preset), 1 (alpha threshold) or
//   2 (max alpha) writes cfg_data at once; other indexes are ignored. Write
//   only while no sample is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and restores preset 0,
//   threshold 0 and max alpha 1.0 (4096).
module transfer_function_rgba_map_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tfrm_pkg::IDX_W-1:0]      in_sample_index,
  input  logic                            cfg_we,
  input  logic [tfrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfrm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  output logic [tfrm_pkg::Q_W-1:0]        out_red,
  output logic [tfrm_pkg::Q_W-1:0]        out_green,
  output logic [tfrm_pkg::Q_W-1:0]        out_blue,
  output logic [tfrm_pkg::Q_W-1:0]        out_opacity
);
  import tfrm_pkg::*;

  // Configuration registers.
  logic [PRESET_W-1:0]    preset_r;
  logic [THR_W-1:0]       alpha_thr_r;
  logic [MAX_ALPHA_W-1:0] max_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preset_r    <= PRESET_RESET;
      alpha_thr_r <= THR_RESET;
      max_alpha_r <= MAX_ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESET:    preset_r    <= cfg_data[PRESET_W-1:0];
        CFG_ALPHA_THR: alpha_thr_r <= cfg_data[THR_W-1:0];
        CFG_MAX_ALPHA: max_alpha_r <= cfg_data[MAX_ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline never holds a sample back.
  assign busy = 1'b0;

  // Stage 1: accept the transaction and clamp the index to the table.
  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [IDX_W-1:0] s1_idx_nxt;

  always_comb begin
    s1_idx_nxt = in_sample_index;
    if ({{(64-IDX_W){1'b0}}, in_sample_index} > TableLast) begin
      s1_idx_nxt = TableLast[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= s1_idx_nxt;
  end

  // Stage 2: position t in Q1.15 by reciprocal multiply, clamped at 1.0.
  logic                s2_valid_r;
  logic [Q_W-1:0]      s2_t_r;
  logic [Q_W-1:0]      s2_t_nxt;
  logic [T_PROD_W-1:0] t_prod;
  logic [T_RAW_W-1:0]  t_raw;

  assign t_prod = T_PROD_W'(s1_idx_r) * T_PROD_W'(T_RECIP);
  assign t_raw  = t_prod[T_PROD_W-1:T_DROP];

  always_comb begin
    if (t_raw > T_RAW_W'(Q_ONE)) begin
      s2_t_nxt = Q_ONE;
    end else begin
      s2_t_nxt = t_raw[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_t_r <= s2_t_nxt;
  end

  // Stage 3: segment, blend weight, endpoint colors and alpha distance.
  logic                     s3_valid_r;
  logic [Q_W-1:0]           s3_u_r;
  q15_t                     s3_a_r    [0:NUM_CH-1];
  logic signed [DIFF_W-1:0] s3_diff_r [0:NUM_CH-1];
  logic [Q_W-1:0]           s3_dist_r;
  logic [Q_W-1:0]           s3_den_r;

  logic                     seg;
  logic [1:0]               seg_lo;
  logic [1:0]               seg_hi;
  logic [Q_W-1:0]           s3_u_nxt;
  q15_t                     s3_a_nxt    [0:NUM_CH-1];
  logic signed [DIFF_W-1:0] s3_diff_nxt [0:NUM_CH-1];
  logic [Q_W-1:0]           s3_dist_nxt;
  logic [Q_W-1:0]           thr_ext;

  assign seg     = (s2_t_r >= Q_HALF);
  assign seg_lo  = {1'b0, seg};
  assign seg_hi  = {seg, ~seg};
  assign thr_ext = {1'b0, alpha_thr_r};

  always_comb begin
    q15_t b_col;
    if (seg) begin
      s3_u_nxt = Q_W'((s2_t_r - Q_HALF) << 1);
    end else begin
      s3_u_nxt = {s2_t_r[Q_W-2:0], 1'b0};
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      b_col           = COLOUR_TAB[preset_r][seg_hi][ch];
      s3_a_nxt[ch]    = COLOUR_TAB[preset_r][seg_lo][ch];
      s3_diff_nxt[ch] = $signed({1'b0, b_col}) - $signed({1'b0, s3_a_nxt[ch]});
    end
    if (s2_t_r >= thr_ext) begin
      s3_dist_nxt = s2_t_r - thr_ext;
    end else begin
      s3_dist_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_u_r    <= s3_u_nxt;
    s3_dist_r <= s3_dist_nxt;
    s3_den_r  <= Q_ONE - thr_ext;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s3_a_r[ch]    <= s3_a_nxt[ch];
      s3_diff_r[ch] <= s3_diff_nxt[ch];
    end
  end

  // Stage 4: one multiply per color lane and one for the alpha ramp.
  logic                      s4_valid_r;
  q15_t                      s4_a_r     [0:NUM_CH-1];
  logic signed [CPROD_W-1:0] s4_cprod_r [0:NUM_CH-1];
  logic [APROD_W-1:0]        s4_aprod_r;
  logic [Q_W-1:0]            s4_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s4_a_r[ch]     <= s3_a_r[ch];
      s4_cprod_r[ch] <= s3_diff_r[ch] * $signed({1'b0, s3_u_r});
    end
    s4_aprod_r <= APROD_W'(max_alpha_r) * APROD_W'(s3_dist_r);
    s4_den_r   <= s3_den_r;
  end

  // Stage 5: finish the blend and set up the opacity division.
  rgb_t                      rgb_r [0:DIV_STAGES];
  rgb_t                      rgb_nxt;
  div_op_t                   div_in_r;
  div_op_t                   div_in_nxt;
  div_op_t                   div_out;
  logic [NUM_W-1:0]          num;
  logic signed [CPROD_W-1:0] blend_sum [0:NUM_CH-1];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      blend_sum[ch] = (s4_cprod_r[ch] >>> 15)
                    + $signed({{(CPROD_W-Q_W){1'b0}}, s4_a_r[ch]});
    end
    rgb_nxt.red   = blend_sum[0][Q_W-1:0];
    rgb_nxt.green = blend_sum[1][Q_W-1:0];
    rgb_nxt.blue  = blend_sum[2][Q_W-1:0];
  end

  // Quotients of 1.0 or more saturate, so only 15 bits remain to divide.
  assign num = {s4_aprod_r, 3'b000};

  always_comb begin
    div_in_nxt.valid = s4_valid_r;
    div_in_nxt.sat   = (num >= {{(NUM_W-Q_W-15){1'b0}}, s4_den_r, 15'd0});
    div_in_nxt.rem   = num[REM_W-1:0];
    div_in_nxt.den   = s4_den_r;
    div_in_nxt.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_in_r.valid <= 1'b0;
    end else begin
      div_in_r <= div_in_nxt;
    end
  end

  // Color delay line that keeps pace with the divider.
  always_ff @(posedge clk) begin
    rgb_r[0] <= rgb_nxt;
    for (int i = 1; i <= DIV_STAGES; i++) begin
      rgb_r[i] <= rgb_r[i-1];
    end
  end

  tfrm_alpha_div u_alpha_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .op_in  (div_in_r),
    .op_out (div_out)
  );

  // Result transaction.
  assign out_valid   = div_out.valid;
  assign out_red     = rgb_r[DIV_STAGES].red;
  assign out_green   = rgb_r[DIV_STAGES].green;
  assign out_blue    = rgb_r[DIV_STAGES].blue;
  assign out_opacity = div_out.sat ? Q_ONE : {1'b0, div_out.quo};

endmodule

@@ hw/rtl/tfrm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the transfer function map and its bind to the top level.
module tfrm_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [tfrm_pkg::Q_W-1:0] out_red,
  input logic [tfrm_pkg::Q_W-1:0] out_green,
  input logic [tfrm_pkg::Q_W-1:0] out_blue,
  input logic [tfrm_pkg::Q_W-1:0] out_opacity
);
  import tfrm_pkg::*;

  // Every accepted transaction yields a result after the fixed latency.
  a_result_follows: assert property (
    @(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid
  ) else $error("accepted sample produced no result at the expected cycle");

  // No result appears without a matching accepted transaction.
  a_no_spurious: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY)
  ) else $error("result strobe without a matching accepted sample");

  // Colors stay within 0 to 1.0 in Q1.15.
  a_color_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= Q_ONE && out_green <= Q_ONE && out_blue <= Q_ONE)
  ) else $error("color channel above 1.0");

  // Opacity is saturated at 1.0.
  a_opacity_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_opacity <= Q_ONE)
  ) else $error("opacity above 1.0");

endmodule

bind transfer_function_rgba_map_top tfrm_checker u_tfrm_checker (.*);
